// ===== hw/rtl/grid_neighbour_average_sweep_unit_defines.svh =====
// Assertion macros for the grid neighbour average sweep unit.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef GRID_NEIGHBOUR_AVERAGE_SWEEP_UNIT_DEFINES_SVH
`define GRID_NEIGHBOUR_AVERAGE_SWEEP_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define GNAS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define GNAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/gnas_pkg.sv =====
// Shared constants, codes and types of the grid neighbour average sweep unit.
// No dependencies.
package gnas_pkg;

   localparam int MAX_ROWS_DEF = 64;
   localparam int MAX_COLS_DEF = 64;

   localparam int DATA_W     = 32;
   localparam int SUM_W      = 35;
   localparam int LIM_W      = 11;
   localparam int TERM_W     = 3;
   localparam int DIV_STEP_W = 6;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int SIZE_W     = 7;
   localparam int SWEEP_W    = 16;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_RUN   = 2'd2;

   localparam logic [1:0] REG_ROWS   = 2'd0;
   localparam logic [1:0] REG_COLS   = 2'd1;
   localparam logic [1:0] REG_SWEEPS = 2'd2;

   localparam logic [SIZE_W-1:0]  ROWS_RST   = 7'd64;
   localparam logic [SIZE_W-1:0]  COLS_RST   = 7'd64;
   localparam logic [SWEEP_W-1:0] SWEEPS_RST = 16'd1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== hw/rtl/gnas_req_if.sv =====
// Request channel of the grid neighbour average sweep unit.
// Depends on gnas_pkg.
interface gnas_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    cmd;
   logic [5:0]                    row;
   logic [5:0]                    col;
   logic signed [gnas_pkg::DATA_W-1:0] value;

   modport source (output valid, cmd, row, col, value, input ready);
   modport sink   (input valid, cmd, row, col, value, output ready);
endinterface

// ===== hw/rtl/gnas_rsp_if.sv =====
// Response channel of the grid neighbour average sweep unit.
// Depends on gnas_pkg.
interface gnas_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    done_cmd;
   logic signed [gnas_pkg::DATA_W-1:0] read_value;

   modport source (output valid, done_cmd, read_value, input ready);
   modport sink   (input valid, done_cmd, read_value, output ready);
endinterface

// ===== hw/rtl/grid_neighbour_average_sweep_unit.sv =====
// Five-point Jacobi averaging unit over a MAX_ROWS x MAX_COLS grid of Q16.16
// values held in two ping-pong stores. After reset the unit clears both stores
// and takes no transaction while it does so. A write, an unknown command or a
// run with a sweep count of zero answers in the cycle after acceptance; a read
// answers after a pass through the read-wait state. In a run each cell needs up
// to five reads through the single read port of the current store and a 35-step
// bit-serial division by the term count. One transaction is in work at a time;
// the next is taken once the response has been taken. Depends on gnas_pkg, the
// channel interfaces, gnas_store, gnas_div and the assertion header.
`include "grid_neighbour_average_sweep_unit_defines.svh"

module grid_neighbour_average_sweep_unit #(
   parameter int MAX_ROWS = gnas_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = gnas_pkg::MAX_COLS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   gnas_req_if.sink                          req_bus,
   gnas_rsp_if.source                        rsp_bus,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [gnas_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [gnas_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [gnas_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int AW    = ROW_W + COL_W;
   localparam int LW    = gnas_pkg::LIM_W;
   localparam int DW    = gnas_pkg::DATA_W;
   localparam int SW    = gnas_pkg::SUM_W;
   localparam int TW    = gnas_pkg::TERM_W;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_RDWAIT = 3'd2;
   localparam logic [2:0] S_ISSUE  = 3'd3;
   localparam logic [2:0] S_ACC    = 3'd4;
   localparam logic [2:0] S_START  = 3'd5;
   localparam logic [2:0] S_DIV    = 3'd6;

   localparam logic [TW-1:0] K_CENTER = 3'd0;
   localparam logic [TW-1:0] K_UP     = 3'd1;
   localparam logic [TW-1:0] K_DOWN   = 3'd2;
   localparam logic [TW-1:0] K_LEFT   = 3'd3;
   localparam logic [TW-1:0] K_RIGHT  = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic                          cur_is_b_ff, cur_is_b_in;
   logic [ROW_W-1:0]              y_ff, y_in;
   logic [COL_W-1:0]              x_ff, x_in;
   logic [TW-1:0]                 k_ff, k_in;
   logic [TW-1:0]                 cnt_ff, cnt_in;
   logic signed [SW-1:0]          sum_ff, sum_in;
   logic [gnas_pkg::SWEEP_W-1:0]  sweep_ff, sweep_in;
   logic [AW-1:0]                 clr_ff, clr_in;
   logic                          rd_ok_ff, rd_ok_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [1:0]                    rsp_cmd_ff, rsp_cmd_in;
   logic [DW-1:0]                 rsp_data_ff, rsp_data_in;
   logic [gnas_pkg::SIZE_W-1:0]   rows_ff, rows_in;
   logic [gnas_pkg::SIZE_W-1:0]   cols_ff, cols_in;
   logic [gnas_pkg::SWEEP_W-1:0]  sweeps_ff, sweeps_in;

   logic [AW-1:0]         rd_addr, wr_addr, req_addr;
   logic [DW-1:0]         wr_data, rdata_a, rdata_b, cur_rdata;
   logic                  we_cur, we_nxt, we_all;
   logic                  we_a, we_b;
   logic                  req_fire, rsp_fire, csr_write, addr_ok;
   logic [LW-1:0]         m_lim, n_lim;
   logic                  in_region, term_en, last_cell, last_sweep;
   logic                  div_start;
   logic signed [DW-1:0]  div_quo;
   gnas_pkg::div_stat_type div_stat;

   assign req_fire  = req_bus.valid && req_bus.ready;
   assign rsp_fire  = rsp_bus.valid && rsp_bus.ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign addr_ok   = (LW'(req_bus.row) < LW'(MAX_ROWS)) && (LW'(req_bus.col) < LW'(MAX_COLS));
   assign req_addr  = {ROW_W'(req_bus.row), COL_W'(req_bus.col)};

   assign m_lim = (rows_ff == '0) ? LW'(1) :
                  ((LW'(rows_ff) > LW'(MAX_ROWS)) ? LW'(MAX_ROWS) : LW'(rows_ff));
   assign n_lim = (cols_ff == '0) ? LW'(1) :
                  ((LW'(cols_ff) > LW'(MAX_COLS)) ? LW'(MAX_COLS) : LW'(cols_ff));
   assign in_region  = (LW'(y_ff) < m_lim) && (LW'(x_ff) < n_lim);
   assign last_cell  = (y_ff == ROW_W'(MAX_ROWS - 1)) && (x_ff == COL_W'(MAX_COLS - 1));
   assign last_sweep = (sweep_ff == sweeps_ff - 1'b1);
   assign cur_rdata  = cur_is_b_ff ? rdata_b : rdata_a;

   always_comb begin
      case (k_ff)
         K_CENTER: term_en = 1'b1;
         K_UP:     term_en = in_region && (y_ff != '0);
         K_DOWN:   term_en = in_region && (LW'(y_ff) + LW'(1) < m_lim);
         K_LEFT:   term_en = in_region && (x_ff != '0);
         K_RIGHT:  term_en = in_region && (LW'(x_ff) + LW'(1) < n_lim);
         default:  term_en = 1'b0;
      endcase
   end

   always_comb begin
      rd_addr = req_addr;
      if (state_ff != S_IDLE) begin
         case (k_ff)
            K_UP:    rd_addr = {ROW_W'(y_ff - 1'b1), x_ff};
            K_DOWN:  rd_addr = {ROW_W'(y_ff + 1'b1), x_ff};
            K_LEFT:  rd_addr = {y_ff, COL_W'(x_ff - 1'b1)};
            K_RIGHT: rd_addr = {y_ff, COL_W'(x_ff + 1'b1)};
            default: rd_addr = {y_ff, x_ff};
         endcase
      end
   end

   always_comb begin
      state_in    = state_ff;
      cur_is_b_in = cur_is_b_ff;
      y_in        = y_ff;
      x_in        = x_ff;
      k_in        = k_ff;
      cnt_in      = cnt_ff;
      sum_in      = sum_ff;
      sweep_in    = sweep_ff;
      clr_in      = clr_ff;
      rd_ok_in    = rd_ok_ff;
      rsp_valid_in = rsp_fire ? 1'b0 : rsp_valid_ff;
      rsp_cmd_in  = rsp_cmd_ff;
      rsp_data_in = rsp_data_ff;
      we_cur      = 1'b0;
      we_nxt      = 1'b0;
      we_all      = 1'b0;
      wr_addr     = req_addr;
      wr_data     = req_bus.value;
      div_start   = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            we_all  = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               rsp_cmd_in  = req_bus.cmd;
               rsp_data_in = '0;
               case (req_bus.cmd)
                  gnas_pkg::CMD_WRITE: begin
                     we_cur       = addr_ok;
                     rsp_valid_in = 1'b1;
                  end
                  gnas_pkg::CMD_READ: begin
                     rd_ok_in = addr_ok;
                     state_in = S_RDWAIT;
                  end
                  gnas_pkg::CMD_RUN: begin
                     if (sweeps_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        y_in     = '0;
                        x_in     = '0;
                        k_in     = K_CENTER;
                        cnt_in   = '0;
                        sum_in   = '0;
                        sweep_in = '0;
                        state_in = S_ISSUE;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_RDWAIT: begin
            rsp_data_in  = rd_ok_ff ? cur_rdata : '0;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_ISSUE: begin
            if (term_en) begin
               state_in = S_ACC;
            end else if (k_ff == K_RIGHT) begin
               state_in = S_START;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_ACC: begin
            sum_in = sum_ff + SW'(signed'(cur_rdata));
            cnt_in = cnt_ff + 1'b1;
            if (k_ff == K_RIGHT) begin
               state_in = S_START;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_ISSUE;
            end
         end
         S_START: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            wr_addr = {y_ff, x_ff};
            wr_data = div_quo;
            if (div_stat.done) begin
               we_nxt = 1'b1;
               k_in   = K_CENTER;
               cnt_in = '0;
               sum_in = '0;
               state_in = S_ISSUE;
               if (x_ff == COL_W'(MAX_COLS - 1)) begin
                  x_in = '0;
                  y_in = y_ff + 1'b1;
               end else begin
                  x_in = x_ff + 1'b1;
               end
               if (last_cell) begin
                  y_in        = '0;
                  cur_is_b_in = !cur_is_b_ff;
                  sweep_in    = sweep_ff + 1'b1;
                  if (last_sweep) begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign we_a = we_all || (we_cur && !cur_is_b_ff) || (we_nxt && cur_is_b_ff);
   assign we_b = we_all || (we_cur && cur_is_b_ff) || (we_nxt && !cur_is_b_ff);

   always_comb begin
      rows_in   = rows_ff;
      cols_in   = cols_ff;
      sweeps_in = sweeps_ff;
      if (csr_write) begin
         case (csr_paddr[3:2])
            gnas_pkg::REG_ROWS:   rows_in   = csr_pwdata[gnas_pkg::SIZE_W-1:0];
            gnas_pkg::REG_COLS:   cols_in   = csr_pwdata[gnas_pkg::SIZE_W-1:0];
            gnas_pkg::REG_SWEEPS: sweeps_in = csr_pwdata[gnas_pkg::SWEEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         gnas_pkg::REG_ROWS:   csr_prdata = gnas_pkg::CSR_DATA_W'(rows_ff);
         gnas_pkg::REG_COLS:   csr_prdata = gnas_pkg::CSR_DATA_W'(cols_ff);
         gnas_pkg::REG_SWEEPS: csr_prdata = gnas_pkg::CSR_DATA_W'(sweeps_ff);
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cur_is_b_ff  <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rows_ff      <= gnas_pkg::ROWS_RST;
         cols_ff      <= gnas_pkg::COLS_RST;
         sweeps_ff    <= gnas_pkg::SWEEPS_RST;
         y_ff         <= '0;
         x_ff         <= '0;
         k_ff         <= K_CENTER;
         sweep_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         cur_is_b_ff  <= cur_is_b_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         sweeps_ff    <= sweeps_in;
         y_ff         <= y_in;
         x_ff         <= x_in;
         k_ff         <= k_in;
         sweep_ff     <= sweep_in;
      end
      cnt_ff      <= cnt_in;
      sum_ff      <= sum_in;
      rd_ok_ff    <= rd_ok_in;
      rsp_cmd_ff  <= rsp_cmd_in;
      rsp_data_ff <= rsp_data_in;
   end

   gnas_store #(.ADDR_W(AW)) u_store_a (
      .clock (clock),
      .we    (we_a),
      .waddr (wr_addr),
      .wdata (wr_data),
      .raddr (rd_addr),
      .rdata (rdata_a)
   );

   gnas_store #(.ADDR_W(AW)) u_store_b (
      .clock (clock),
      .we    (we_b),
      .waddr (wr_addr),
      .wdata (wr_data),
      .raddr (rd_addr),
      .rdata (rdata_b)
   );

   gnas_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (cnt_ff),
      .quotient (div_quo),
      .status   (div_stat)
   );

   assign req_bus.ready      = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.done_cmd   = rsp_cmd_ff;
   assign rsp_bus.read_value = rsp_data_ff;
   assign csr_pready         = 1'b1;

   `GNAS_ASSERT_NOW(a_div_done_in_div, clock, reset, div_stat.done, (state_ff == S_DIV), "divider finished outside divide state")
   `GNAS_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_fire, !rsp_bus.valid, "response reappeared right after transaction")
   `GNAS_ASSERT_NOW(a_swap_on_write, clock, reset, (cur_is_b_ff != $past(cur_is_b_ff)), ($past(state_ff) == S_DIV), "store roles swapped outside sweep end")

endmodule

// ===== hw/rtl/gnas_store.sv =====
// One grid store: single write port, single registered read port.
// Depends on gnas_pkg.
module gnas_store #(
   parameter int ADDR_W = 12
) (
   input  logic                        clock,
   input  logic                        we,
   input  logic [ADDR_W-1:0]           waddr,
   input  logic [gnas_pkg::DATA_W-1:0] wdata,
   input  logic [ADDR_W-1:0]           raddr,
   output logic [gnas_pkg::DATA_W-1:0] rdata
);

   logic [gnas_pkg::DATA_W-1:0] mem_ff [2**ADDR_W];
   logic [gnas_pkg::DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/gnas_div.sv =====
// Bit-serial signed divider by a small term count, truncating toward zero.
// Depends on gnas_pkg.
module gnas_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [gnas_pkg::SUM_W-1:0] dividend,
   input  logic [gnas_pkg::TERM_W-1:0]       divisor,
   output logic signed [gnas_pkg::DATA_W-1:0] quotient,
   output gnas_pkg::div_stat_type            status
);

   localparam int SW = gnas_pkg::SUM_W;
   localparam int TW = gnas_pkg::TERM_W;

   logic [SW-1:0]                  quo_ff, quo_in;
   logic [TW-1:0]                  rem_ff, rem_in;
   logic [TW-1:0]                  dvs_ff, dvs_in;
   logic                           neg_ff, neg_in;
   logic [gnas_pkg::DIV_STEP_W-1:0] step_ff, step_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [TW:0]                    shifted;
   logic                           ge;
   logic [SW-1:0]                  mag;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      mag     = dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
      shifted = {rem_ff, quo_ff[SW-1]};
      ge      = shifted >= {1'b0, dvs_ff};
      if (start) begin
         quo_in  = mag;
         rem_in  = '0;
         dvs_in  = divisor;
         neg_in  = dividend[SW-1];
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? TW'(shifted - {1'b0, dvs_ff}) : TW'(shifted);
         quo_in  = {quo_ff[SW-2:0], ge};
         step_in = step_ff + 1'b1;
         if (step_ff == gnas_pkg::DIV_STEP_W'(SW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
      step_ff <= step_in;
   end

   assign quotient    = neg_ff ? gnas_pkg::DATA_W'(-quo_ff) : gnas_pkg::DATA_W'(quo_ff);
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== sim/grid_average_checker.sv =====
// Checker for the grid neighbour average sweep unit: watches the request,
// response and register ports, predicts each response and compares in order.
// Depends on gnas_pkg and the gnas_req_if / gnas_rsp_if channel interfaces.
module grid_average_checker (
   input  logic                            clock,
   input  logic                            reset,
   gnas_req_if                             req_bus,
   gnas_rsp_if                             rsp_bus,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic                            csr_pready,
   input  logic [gnas_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [gnas_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output int                              fail_count,
   output int                              pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CELLS = gnas_pkg::MAX_ROWS_DEF * gnas_pkg::MAX_COLS_DEF;

   typedef struct packed {
      logic [1:0]                         cmd;
      logic signed [gnas_pkg::DATA_W-1:0] value;
   } answer_type;

   logic signed [gnas_pkg::DATA_W-1:0] grid [2][CELLS];
   bit                                 cur_sel;
   logic [gnas_pkg::SIZE_W-1:0]        rows_cfg;
   logic [gnas_pkg::SIZE_W-1:0]        cols_cfg;
   logic [gnas_pkg::SWEEP_W-1:0]       sweeps_cfg;
   answer_type                         answers [$];

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic int clamp_dim(input int v, input int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic average_sweep();
      int     m, n, at, cnt;
      longint sum;
      bit     src;
      m   = clamp_dim(rows_cfg, gnas_pkg::MAX_ROWS_DEF);
      n   = clamp_dim(cols_cfg, gnas_pkg::MAX_COLS_DEF);
      src = cur_sel;
      grid[!src] = grid[src];
      for (int y = 0; y < m; y++) begin
         for (int x = 0; x < n; x++) begin
            at  = y * gnas_pkg::MAX_COLS_DEF + x;
            sum = grid[src][at];
            cnt = 1;
            if (y > 0) begin sum += grid[src][at - gnas_pkg::MAX_COLS_DEF]; cnt++; end
            if (y + 1 < m) begin sum += grid[src][at + gnas_pkg::MAX_COLS_DEF]; cnt++; end
            if (x > 0) begin sum += grid[src][at - 1]; cnt++; end
            if (x + 1 < n) begin sum += grid[src][at + 1]; cnt++; end
            grid[!src][at] = gnas_pkg::DATA_W'(sum / cnt);
         end
      end
      cur_sel = !src;
   endtask

   initial begin
      fail_count = 0;
      pending    = 0;
      cur_sel    = 0;
      rows_cfg   = gnas_pkg::ROWS_RST;
      cols_cfg   = gnas_pkg::COLS_RST;
      sweeps_cfg = gnas_pkg::SWEEPS_RST;
      for (int i = 0; i < CELLS; i++) begin
         grid[0][i] = '0;
         grid[1][i] = '0;
      end
   end

   always @(posedge clock) begin
      answer_type a, want;
      int         at;
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               gnas_pkg::REG_ROWS:   rows_cfg   = csr_pwdata[gnas_pkg::SIZE_W-1:0];
               gnas_pkg::REG_COLS:   cols_cfg   = csr_pwdata[gnas_pkg::SIZE_W-1:0];
               gnas_pkg::REG_SWEEPS: sweeps_cfg = csr_pwdata[gnas_pkg::SWEEP_W-1:0];
               default: ;
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (answers.size() == 0) begin
               report("unexpected transaction", rsp_bus.done_cmd, -1);
            end else begin
               want = answers.pop_front();
               if (rsp_bus.done_cmd !== want.cmd)
                  report("done_cmd", rsp_bus.done_cmd, want.cmd);
               if (rsp_bus.read_value !== want.value)
                  report("read_value", rsp_bus.read_value, want.value);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            at      = req_bus.row * gnas_pkg::MAX_COLS_DEF + req_bus.col;
            a.cmd   = req_bus.cmd;
            a.value = '0;
            case (req_bus.cmd)
               gnas_pkg::CMD_WRITE: grid[cur_sel][at] = req_bus.value;
               gnas_pkg::CMD_READ:  a.value = grid[cur_sel][at];
               gnas_pkg::CMD_RUN:   for (int s = 0; s < sweeps_cfg; s++) average_sweep();
               default: ;
            endcase
            answers.push_back(a);
         end
         pending = answers.size();
      end
   end
endmodule

// ===== sim/testbench.sv =====
// Top of the grid neighbour average sweep unit testbench: clock, reset,
// stimulus, register writes, response stalls and the verdict.
// Depends on gnas_pkg, the channel interfaces, the unit and grid_average_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint CYCLE_LIMIT = 12_000_000;
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;

   logic                            clock = 0;
   logic                            reset = 1;
   logic                            csr_psel = 0;
   logic                            csr_penable = 0;
   logic                            csr_pwrite = 0;
   logic [gnas_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [gnas_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [gnas_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;
   int                              fail_count;
   int                              pending;
   bit                              calm = 0;
   bit                              long_hold = 0;
   longint                          cycles = 0;

   gnas_req_if req_bus ();
   gnas_rsp_if rsp_bus ();

   grid_neighbour_average_sweep_unit dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   grid_average_checker checker_i (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_pready(csr_pready), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .fail_count(fail_count), .pending(pending)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      rsp_bus.ready = 0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_bus.ready = 0;
            repeat (300) @(negedge clock);
            long_hold = 0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready = 0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
         rsp_bus.ready = 1;
      end
   end

   task automatic write_reg(input logic [1:0] idx, input int unsigned data);
      @(negedge clock);
      csr_psel   = 1;
      csr_pwrite = 1;
      csr_paddr  = {idx, 2'b00};
      csr_pwdata = data;
      @(negedge clock);
      csr_penable = 1;
      @(negedge clock);
      csr_psel    = 0;
      csr_penable = 0;
      csr_pwrite  = 0;
   endtask

   task automatic send(input logic [1:0] cmd, input logic [5:0] row, input logic [5:0] col,
                       input logic [31:0] value);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_bus.valid = 0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_bus.valid = 1;
      req_bus.cmd   = cmd;
      req_bus.row   = row;
      req_bus.col   = col;
      req_bus.value = value;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic settle();
      req_bus.valid = 0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic random_phase(input int count, input int runs_allowed);
      int          r;
      logic [5:0]  row, col;
      logic [31:0] data;
      for (int i = 0; i < count; i++) begin
         r    = $urandom_range(0, 99);
         row  = 6'($urandom_range(0, 63));
         col  = 6'($urandom_range(0, 63));
         data = $urandom;
         if (r < 50) send(gnas_pkg::CMD_WRITE, row, col, data);
         else if (r < 55) send(gnas_pkg::CMD_WRITE, {4'b0, row[1:0]}, {4'b0, col[1:0]}, data);
         else if (r < 90) send(gnas_pkg::CMD_READ, row, col, data);
         else if (r < 95 || runs_allowed == 0) send(CMD_UNKNOWN, row, col, data);
         else begin
            send(gnas_pkg::CMD_RUN, row, col, data);
            runs_allowed--;
         end
      end
   endtask

   initial begin
      req_bus.valid = 0;
      req_bus.cmd   = gnas_pkg::CMD_WRITE;
      req_bus.row   = '0;
      req_bus.col   = '0;
      req_bus.value = '0;
      repeat (8) @(negedge clock);
      reset = 0;

      send(gnas_pkg::CMD_READ, 6'd63, 6'd63, 32'h0);
      send(gnas_pkg::CMD_WRITE, 6'd0, 6'd0, 32'h7FFF_FFFF);
      send(gnas_pkg::CMD_WRITE, 6'd0, 6'd1, 32'h7FFF_FFFF);
      send(gnas_pkg::CMD_WRITE, 6'd1, 6'd0, 32'h8000_0000);
      send(gnas_pkg::CMD_WRITE, 6'd63, 6'd63, 32'h8000_0000);
      send(gnas_pkg::CMD_WRITE, 6'd63, 6'd62, 32'hFFFF_FFFF);
      send(gnas_pkg::CMD_WRITE, 6'd5, 6'd7, 32'h0001_0000);
      send(gnas_pkg::CMD_READ, 6'd0, 6'd0, 32'hFFFF_FFFF);
      send(gnas_pkg::CMD_READ, 6'd63, 6'd63, 32'h0);
      send(CMD_UNKNOWN, 6'd63, 6'd63, 32'hFFFF_FFFF);
      send(gnas_pkg::CMD_RUN, 6'd0, 6'd0, 32'h0);
      send(gnas_pkg::CMD_READ, 6'd0, 6'd0, 32'h0);
      send(gnas_pkg::CMD_READ, 6'd63, 6'd63, 32'h0);
      send(gnas_pkg::CMD_READ, 6'd5, 6'd6, 32'h0);
      settle();

      write_reg(gnas_pkg::REG_ROWS, 0);
      write_reg(gnas_pkg::REG_COLS, 127);
      write_reg(gnas_pkg::REG_SWEEPS, 2);
      send(gnas_pkg::CMD_WRITE, 6'd0, 6'd10, 32'h8000_0000);
      send(gnas_pkg::CMD_WRITE, 6'd1, 6'd10, 32'h1234_5678);
      send(gnas_pkg::CMD_RUN, 6'd0, 6'd0, 32'h0);
      send(gnas_pkg::CMD_READ, 6'd0, 6'd10, 32'h0);
      send(gnas_pkg::CMD_READ, 6'd1, 6'd10, 32'h0);
      settle();

      write_reg(gnas_pkg::REG_ROWS, 3);
      write_reg(gnas_pkg::REG_COLS, 1);
      write_reg(gnas_pkg::REG_SWEEPS, 0);
      send(gnas_pkg::CMD_RUN, 6'd0, 6'd0, 32'h0);
      send(gnas_pkg::CMD_READ, 6'd0, 6'd0, 32'h0);
      long_hold = 1;
      random_phase(30, 4);
      settle();

      write_reg(gnas_pkg::REG_SWEEPS, 65535);
      write_reg(gnas_pkg::REG_ROWS, 64);
      random_phase(30, 0);
      settle();

      write_reg(gnas_pkg::REG_ROWS, 6);
      write_reg(gnas_pkg::REG_COLS, 5);
      write_reg(gnas_pkg::REG_SWEEPS, 1);
      for (int i = 0; i < 10; i++)
         send(gnas_pkg::CMD_WRITE, 6'($urandom_range(0, 6)), 6'($urandom_range(0, 5)), $urandom);
      random_phase(20, 2);
      settle();

      write_reg(gnas_pkg::REG_ROWS, 127);
      write_reg(gnas_pkg::REG_COLS, 64);
      calm = 1;
      random_phase(30, 1);
      send(gnas_pkg::CMD_READ, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), 32'h0);
      settle();
      repeat (50) @(negedge clock);

      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/gnas_pkg.sv
hw/rtl/gnas_req_if.sv
hw/rtl/gnas_rsp_if.sv
hw/rtl/gnas_store.sv
hw/rtl/gnas_div.sv
hw/rtl/grid_neighbour_average_sweep_unit.sv
sim/grid_average_checker.sv
sim/testbench.sv
